// ----- rtl/skp_pkg.sv -----
// shared types and constants of the sparse coo kronecker product unit
`timescale 1ns / 1ps
`default_nettype none

package skp_pkg;

    // default parameter values
    localparam int DEF_RIGHT_DEPTH = 64;
    localparam int DEF_VALUE_BITS  = 16;
    localparam int MAX_VALUE_BITS  = 32;

    // fixed field widths
    localparam int COORD_W   = 16;
    localparam int INDEX_W   = 32;
    localparam int PRODUCT_W = 32;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;

    // input item modes
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_LEFT = 1'b1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RIGHT_ROWS = 1'b0,
        CFG_RIGHT_COLS = 1'b1
    } cfg_reg_e;

    // command passed from the front end to the back end
    typedef struct packed {
        logic                      is_left;
        logic [MAX_VALUE_BITS-1:0] value;
        logic [COORD_W-1:0]        row;
        logic [COORD_W-1:0]        col;
        logic [INDEX_W-1:0]        row_base;
        logic [INDEX_W-1:0]        col_base;
        logic                      new_set;
        logic                      is_final;
    } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/skp_in_if.sv -----
// input item channel of the kronecker product unit
`timescale 1ns / 1ps
`default_nettype none

interface skp_in_if #(
    parameter int VALUE_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic                         mode;
    logic signed [VALUE_BITS-1:0] entry_value;
    logic [15:0]                  entry_row;
    logic [15:0]                  entry_col;
    logic                         new_set;
    logic                         final_entry;

    modport source (
        output valid, mode, entry_value, entry_row, entry_col, new_set, final_entry,
        input  ready
    );

    modport sink (
        input  valid, mode, entry_value, entry_row, entry_col, new_set, final_entry,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/skp_out_if.sv -----
// result item channel of the kronecker product unit
`timescale 1ns / 1ps
`default_nettype none

interface skp_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] product_value;
    logic [31:0]        out_row_index;
    logic [31:0]        out_col_index;
    logic               run_last;
    logic               product_last;

    modport source (
        output valid, product_value, out_row_index, out_col_index, run_last, product_last,
        input  ready
    );

    modport sink (
        input  valid, product_value, out_row_index, out_col_index, run_last, product_last,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/skp_front.sv -----
// front end: accepts input items and precomputes the scaled left indices
`timescale 1ns / 1ps
`default_nettype none

module skp_front
    import skp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    skp_in_if.sink                  in_ch,
    input  wire logic [CFG_W-1:0]   right_rows,
    input  wire logic [CFG_W-1:0]   right_cols,
    output logic                    cmd_valid,
    input  wire logic               cmd_ready,
    output cmd_t                    cmd
);

    logic f_valid_reg;
    logic f_valid_next;
    cmd_t f_cmd_reg;
    cmd_t f_cmd_next;
    logic accept;

    // stage is free when empty or draining into the queue
    assign in_ch.ready = !f_valid_reg || cmd_ready;
    assign accept      = in_ch.valid && in_ch.ready;
    assign cmd_valid   = f_valid_reg;
    assign cmd         = f_cmd_reg;

    // classify the item and scale the left coordinates
    always_comb
    begin
        f_cmd_next.is_left  = (in_ch.mode == MODE_LEFT);
        f_cmd_next.value    = MAX_VALUE_BITS'(in_ch.entry_value);
        f_cmd_next.row      = in_ch.entry_row;
        f_cmd_next.col      = in_ch.entry_col;
        f_cmd_next.row_base = INDEX_W'(in_ch.entry_row) * INDEX_W'(right_rows);
        f_cmd_next.col_base = INDEX_W'(in_ch.entry_col) * INDEX_W'(right_cols);
        f_cmd_next.new_set  = in_ch.new_set;
        f_cmd_next.is_final = in_ch.final_entry;
    end

    // stage occupancy
    always_comb
    begin
        priority if (accept)
            f_valid_next = 1'b1;
        else if (cmd_ready)
            f_valid_next = 1'b0;
        else
            f_valid_next = f_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_valid_reg <= 1'b0;
        else
            f_valid_reg <= f_valid_next;
    end

    // command payload
    always_ff @(posedge clk)
    begin
        if (accept)
            f_cmd_reg <= f_cmd_next;
    end

endmodule

`default_nettype wire

// ----- rtl/skp_queue.sv -----
// two-entry command queue between front end and back end
`timescale 1ns / 1ps
`default_nettype none

module skp_queue
    import skp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_valid,
    output logic      wr_ready,
    input  wire cmd_t wr_cmd,
    output logic      rd_valid,
    input  wire logic rd_ready,
    output cmd_t      rd_cmd
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       push;
    logic       pop;

    assign wr_ready = (fill_reg != 2'd2);
    assign rd_valid = (fill_reg != 2'd0);
    assign rd_cmd   = slot_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // occupancy count
    always_comb
    begin
        unique case ({push, pop})
            2'b10:   fill_next = fill_reg + 2'd1;
            2'b01:   fill_next = fill_reg - 2'd1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= wr_cmd;
    end

endmodule

`default_nettype wire

// ----- rtl/skp_back.sv -----
// back end: right operand store and the per-entry product sequencer
`timescale 1ns / 1ps
`default_nettype none

module skp_back
    import skp_pkg::*;
#(
    parameter int RIGHT_DEPTH = DEF_RIGHT_DEPTH,
    parameter int VALUE_BITS  = DEF_VALUE_BITS
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cmd_valid,
    output logic      cmd_ready,
    input  wire cmd_t cmd,
    skp_out_if.source out_ch
);

    localparam int IDX_W   = (RIGHT_DEPTH > 1) ? $clog2(RIGHT_DEPTH) : 1;
    localparam int CNT_W   = $clog2(RIGHT_DEPTH + 1);
    localparam int ENTRY_W = VALUE_BITS + 2 * COORD_W;
    localparam int PROD_W  = 2 * VALUE_BITS;

    // right operand store
    logic [ENTRY_W-1:0] store_mem [RIGHT_DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [IDX_W-1:0] k_reg;
    logic [IDX_W-1:0] k_next;
    logic [CNT_W-1:0] cnt_eff;
    logic             mem_we;
    logic             issue;
    logic             issue_last;
    logic             adv;

    // read stage
    logic                         s1_valid_reg;
    logic signed [VALUE_BITS-1:0] s1_lv_reg;
    logic [INDEX_W-1:0]           s1_row_base_reg;
    logic [INDEX_W-1:0]           s1_col_base_reg;
    logic                         s1_last_reg;
    logic                         s1_final_reg;

    // output register
    logic                         out_valid_reg;
    logic signed [PRODUCT_W-1:0]  out_prod_reg;
    logic [INDEX_W-1:0]           out_row_reg;
    logic [INDEX_W-1:0]           out_col_reg;
    logic                         out_run_last_reg;
    logic                         out_prod_last_reg;

    logic signed [VALUE_BITS-1:0] rv;
    logic [COORD_W-1:0]           rrow;
    logic [COORD_W-1:0]           rcol;
    logic signed [PROD_W-1:0]     prod;

    // whole pipeline moves when the output slot frees up
    assign adv        = !out_valid_reg || out_ch.ready;
    assign cnt_eff    = cmd.new_set ? '0 : count_reg;
    assign issue_last = ((CNT_W'(k_reg) + CNT_W'(1)) == count_reg);

    // command sequencing while the output can advance: a load writes the store, a left entry one read per stored entry
    always_comb
    begin
        count_next = count_reg;
        k_next     = k_reg;
        cmd_ready  = 1'b0;
        mem_we     = 1'b0;
        issue      = 1'b0;
        priority if (!(adv && cmd_valid))
        begin
            cmd_ready = 1'b0;
        end
        else if (!cmd.is_left)
        begin
            cmd_ready  = 1'b1;
            mem_we     = (cnt_eff < CNT_W'(RIGHT_DEPTH));
            count_next = mem_we ? (cnt_eff + CNT_W'(1)) : cnt_eff;
        end
        else if (count_reg == '0)
        begin
            cmd_ready = 1'b1;
        end
        else
        begin
            issue = 1'b1;
            if (issue_last)
            begin
                cmd_ready = 1'b1;
                k_next    = '0;
            end
            else
            begin
                k_next = k_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            k_reg         <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            k_reg     <= k_next;
            if (adv)
            begin
                s1_valid_reg  <= issue;
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // store write and registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            store_mem[cnt_eff[IDX_W-1:0]] <= {cmd.value[VALUE_BITS-1:0], cmd.row, cmd.col};
        if (adv)
            rd_data_reg <= store_mem[k_reg];
    end

    // read stage payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_lv_reg       <= cmd.value[VALUE_BITS-1:0];
            s1_row_base_reg <= cmd.row_base;
            s1_col_base_reg <= cmd.col_base;
            s1_last_reg     <= issue_last;
            s1_final_reg    <= cmd.is_final;
        end
    end

    // product and index adds into the output register
    assign rv   = rd_data_reg[ENTRY_W-1 -: VALUE_BITS];
    assign rrow = rd_data_reg[2*COORD_W-1 -: COORD_W];
    assign rcol = rd_data_reg[COORD_W-1:0];
    assign prod = s1_lv_reg * rv;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_prod_reg      <= PRODUCT_W'(prod);
            out_row_reg       <= INDEX_W'(s1_row_base_reg + INDEX_W'(rrow));
            out_col_reg       <= INDEX_W'(s1_col_base_reg + INDEX_W'(rcol));
            out_run_last_reg  <= s1_last_reg;
            out_prod_last_reg <= s1_last_reg && s1_final_reg;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.product_value = out_prod_reg;
    assign out_ch.out_row_index = out_row_reg;
    assign out_ch.out_col_index = out_col_reg;
    assign out_ch.run_last      = out_run_last_reg;
    assign out_ch.product_last  = out_prod_last_reg;

endmodule

`default_nettype wire

// ----- rtl/sparse_coo_kronecker_product_unit.sv -----
// a left entry passes the front stage register, the queue and the read stage
// to the output register; it gives one result per stored right entry (up to
//   RIGHT_DEPTH), one per cycle from the store read port unless the output stalls
// reset: entry count cleared, right_rows and right_cols set to 1, queues emptied;
//   the store is not cleared and holds no defined data until loaded
`timescale 1ns / 1ps
`default_nettype none

module sparse_coo_kronecker_product_unit
    import skp_pkg::*;
#(
    parameter int RIGHT_DEPTH = DEF_RIGHT_DEPTH,
    parameter int VALUE_BITS  = DEF_VALUE_BITS
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    skp_in_if.sink                    in_ch,
    skp_out_if.source                 out_ch,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata
);

    logic [CFG_W-1:0] right_rows_reg;
    logic [CFG_W-1:0] right_cols_reg;

    logic fq_valid;
    logic fq_ready;
    cmd_t fq_cmd;
    logic qb_valid;
    logic qb_ready;
    cmd_t qb_cmd;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            right_rows_reg <= CFG_W'(1);
            right_cols_reg <= CFG_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_e'(cfg_index))
                CFG_RIGHT_ROWS: right_rows_reg <= cfg_wdata;
                CFG_RIGHT_COLS: right_cols_reg <= cfg_wdata;
                default:        right_rows_reg <= right_rows_reg;
            endcase
        end
    end

    skp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .right_rows (right_rows_reg),
        .right_cols (right_cols_reg),
        .cmd_valid  (fq_valid),
        .cmd_ready  (fq_ready),
        .cmd        (fq_cmd)
    );

    skp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_cmd   (fq_cmd),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_cmd   (qb_cmd)
    );

    skp_back #(
        .RIGHT_DEPTH (RIGHT_DEPTH),
        .VALUE_BITS  (VALUE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (qb_valid),
        .cmd_ready (qb_ready),
        .cmd       (qb_cmd),
        .out_ch    (out_ch)
    );

endmodule

`default_nettype wire

// ----- rtl/skp_checker.sv -----
// port-level checks of the kronecker product unit and their binding
`timescale 1ns / 1ps
`default_nettype none

module skp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] out_product_value,
    input wire logic [31:0] out_row_index,
    input wire logic        out_run_last,
    input wire logic        out_product_last
);

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_product_value) && $stable(out_row_index))
        else $error("result payload changed while stalled");

    // end of product only on the end of a run
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_product_last |-> out_run_last)
        else $error("product_last without run_last");

    // no result offered while in reset
    assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result offered during reset");

endmodule

bind sparse_coo_kronecker_product_unit skp_checker u_skp_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_product_value (out_ch.product_value),
    .out_row_index     (out_ch.out_row_index),
    .out_run_last      (out_ch.run_last),
    .out_product_last  (out_ch.product_last)
);

`default_nettype wire

// ----- sim/skp_result_checker.sv -----
// result checker of the sparse coo kronecker product unit: predicts and compares every result
`timescale 1ns / 1ps

module skp_result_checker
    import skp_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    skp_in_if                         in_ch,
    skp_out_if                        out_ch,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    output int                        mismatches,
    output int                        outstanding
);

    typedef struct packed {
        logic signed [PRODUCT_W-1:0] product;
        logic [INDEX_W-1:0]          row;
        logic [INDEX_W-1:0]          col;
        logic                        run_last;
        logic                        product_last;
    } kron_result_t;

    // predicted copy of the registers and of the right operand store
    logic [CFG_W-1:0]                  scale_rows;
    logic [CFG_W-1:0]                  scale_cols;
    logic signed [DEF_VALUE_BITS-1:0]  rhs_val [DEF_RIGHT_DEPTH];
    logic [COORD_W-1:0]                rhs_row [DEF_RIGHT_DEPTH];
    logic [COORD_W-1:0]                rhs_col [DEF_RIGHT_DEPTH];
    int                                rhs_count;

    kron_result_t pending_results[$];

    // one result per stored right entry, in stored order
    function automatic void expand_left_entry(
        logic signed [DEF_VALUE_BITS-1:0] lval,
        logic [COORD_W-1:0]               lrow,
        logic [COORD_W-1:0]               lcol,
        logic                             is_final
    );
        kron_result_t r;
        int           lv;
        int           rv;
        lv = lval;
        for (int k = 0; k < rhs_count; k++)
        begin
            rv = rhs_val[k];
            r.product      = lv * rv;
            r.row          = INDEX_W'(lrow) * INDEX_W'(scale_rows) + INDEX_W'(rhs_row[k]);
            r.col          = INDEX_W'(lcol) * INDEX_W'(scale_cols) + INDEX_W'(rhs_col[k]);
            r.run_last     = (k == rhs_count - 1);
            r.product_last = r.run_last & is_final;
            pending_results.insert(pending_results.size(), r);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        kron_result_t got;
        kron_result_t want;
        if (!rst_n)
        begin
            scale_rows = 1;
            scale_cols = 1;
            rhs_count  = 0;
            pending_results.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            // register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_RIGHT_ROWS: scale_rows = cfg_wdata;
                    CFG_RIGHT_COLS: scale_cols = cfg_wdata;
                    default: ;
                endcase
            end

            // input transfer: load into the store or expand a left entry
            if (in_ch.valid && in_ch.ready)
            begin
                if (in_ch.mode == MODE_LOAD)
                begin
                    if (in_ch.new_set)
                        rhs_count = 0;
                    // loads into a full store are dropped
                    if (rhs_count < DEF_RIGHT_DEPTH)
                    begin
                        rhs_val[rhs_count] = in_ch.entry_value;
                        rhs_row[rhs_count] = in_ch.entry_row;
                        rhs_col[rhs_count] = in_ch.entry_col;
                        rhs_count++;
                    end
                end
                else
                begin
                    expand_left_entry(in_ch.entry_value, in_ch.entry_row, in_ch.entry_col,
                                      in_ch.final_entry);
                end
            end

            // output transfer: compare with the oldest prediction
            if (out_ch.valid && out_ch.ready)
            begin
                got.product      = out_ch.product_value;
                got.row          = out_ch.out_row_index;
                got.col          = out_ch.out_col_index;
                got.run_last     = out_ch.run_last;
                got.product_last = out_ch.product_last;
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, got value %0d row %0d",
                             $time, got.product, got.row,
                             " col %0d run_last %0b product_last %0b",
                             got.col, got.run_last, got.product_last);
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: result mismatch: expected value %0d row %0d col %0d",
                                 $time, want.product, want.row, want.col,
                                 " run_last %0b product_last %0b",
                                 want.run_last, want.product_last);
                        $display("%0t:                  got value %0d row %0d col %0d",
                                 $time, got.product, got.row, got.col,
                                 " run_last %0b product_last %0b",
                                 got.run_last, got.product_last);
                        mismatches++;
                    end
                end
            end

            outstanding = pending_results.size();
        end
    end

endmodule

// ----- sim/sparse_coo_kronecker_product_unit_test.sv -----
// stimulus and verdict for the sparse coo kronecker product unit
`timescale 1ns / 1ps

module sparse_coo_kronecker_product_unit_test;
    import skp_pkg::*;

    localparam int ITEM_TARGET   = 370;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int TIMEOUT_NS    = 100_000_000;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;
    int                   mismatches;
    int                   outstanding;

    int   items_sent  = 0;
    logic steady      = 1'b0;
    logic hold_output = 1'b0;

    skp_in_if #(.VALUE_BITS(DEF_VALUE_BITS)) in_ch ();
    skp_out_if                               out_ch ();

    sparse_coo_kronecker_product_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    skp_result_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // idle length: mostly none or short, now and then long
    function automatic int idle_gap();
        int pick;
        if (steady)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 85)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // random 16 bit field with extra weight on the extremes
    function automatic logic [15:0] rand_field16();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h8000;
            3:       return 16'h7FFF;
            4:       return 16'h0001;
            default: return 16'($urandom);
        endcase
    endfunction

    // one input transfer, called and returning at a falling edge
    task automatic send_entry(
        logic        mode,
        logic [15:0] value,
        logic [15:0] row,
        logic [15:0] col,
        logic        nset,
        logic        fin
    );
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.mode        = mode;
        in_ch.entry_value = value;
        in_ch.entry_row   = row;
        in_ch.entry_col   = col;
        in_ch.new_set     = nset;
        in_ch.final_entry = fin;
        in_ch.valid       = 1'b1;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    // wait until every predicted result has arrived and loads have settled
    task automatic drain();
        in_ch.valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(cfg_reg_e idx, logic [CFG_W-1:0] data);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // result receiver with random stalls and one long hold-off on request
    initial
    begin
        int stall;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_output)
            begin
                out_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_output = 1'b0;
            end
            stall = idle_gap();
            if (stall > 0)
            begin
                out_ch.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ch.ready = 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
    end

    // stimulus and verdict
    initial
    begin
        int set_size;
        int lefts;
        int stage_no;
        in_ch.valid       = 1'b0;
        in_ch.mode        = MODE_LOAD;
        in_ch.entry_value = '0;
        in_ch.entry_row   = '0;
        in_ch.entry_col   = '0;
        in_ch.new_set     = 1'b0;
        in_ch.final_entry = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = CFG_RIGHT_ROWS;
        cfg_wdata         = '0;
        rst_n             = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // left entry with an empty store gives nothing
        send_entry(MODE_LEFT, 16'h7FFF, 16'h0001, 16'h0002, 1'b0, 1'b1);

        // right operand with extreme values, final flag in load mode is ignored
        send_entry(MODE_LOAD, 16'h8000, 16'h0000, 16'h0000, 1'b0, 1'b1);
        send_entry(MODE_LOAD, 16'h7FFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
        send_entry(MODE_LOAD, 16'hFFFF, 16'h0001, 16'h0002, 1'b0, 1'b1);
        send_entry(MODE_LOAD, 16'h0000, 16'h1234, 16'h4321, 1'b0, 1'b0);

        // left entries at the extremes, new_set in left mode is ignored
        send_entry(MODE_LEFT, 16'h8000, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
        send_entry(MODE_LEFT, 16'h7FFF, 16'h0000, 16'h0000, 1'b0, 1'b0);
        send_entry(MODE_LEFT, 16'h0001, 16'h0003, 16'h0005, 1'b1, 1'b1);

        // largest scale factors and indices
        drain();
        write_reg(CFG_RIGHT_ROWS, 16'hFFFF);
        write_reg(CFG_RIGHT_COLS, 16'hFFFF);
        send_entry(MODE_LEFT, 16'h8000, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1);
        // fresh right operand, largest positive product
        send_entry(MODE_LOAD, 16'h8000, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
        send_entry(MODE_LEFT, 16'h8000, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1);

        // zero scale factors, then an appended entry
        drain();
        write_reg(CFG_RIGHT_ROWS, 16'h0000);
        write_reg(CFG_RIGHT_COLS, 16'h0000);
        send_entry(MODE_LEFT, 16'h1234, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1);
        send_entry(MODE_LOAD, 16'h7FFF, 16'h0000, 16'hFFFF, 1'b0, 1'b0);
        send_entry(MODE_LEFT, 16'h8001, 16'h0007, 16'h0009, 1'b0, 1'b1);

        // random stages: new settings, then right operands each followed by left entries
        stage_no = 0;
        while (items_sent < ITEM_TARGET)
        begin
            drain();
            write_reg(CFG_RIGHT_ROWS, rand_field16());
            write_reg(CFG_RIGHT_COLS, rand_field16());
            steady = (stage_no % 4 == 3);
            // long output hold-off while a full store expands
            if (stage_no == 2)
                hold_output = 1'b1;
            for (int s = 0; s < 3; s++)
            begin
                // a full store in two stages, one of them overfilled
                if (s == 0 && stage_no == 2)
                    set_size = DEF_RIGHT_DEPTH;
                else if (s == 0 && stage_no == 6)
                    set_size = DEF_RIGHT_DEPTH + 4;
                else
                    set_size = $urandom_range(0, 6);
                // mostly a fresh set, sometimes appended or restarted midway
                for (int k = 0; k < set_size; k++)
                    send_entry(MODE_LOAD, rand_field16(), rand_field16(), rand_field16(),
                               (k == 0) ? ($urandom_range(0, 4) != 0)
                                        : ($urandom_range(0, 19) == 0),
                               1'($urandom_range(0, 1)));
                lefts = (stage_no == 2) ? 6 : $urandom_range(1, 5);
                for (int k = 0; k < lefts; k++)
                    send_entry(MODE_LEFT, rand_field16(), rand_field16(), rand_field16(),
                               1'($urandom_range(0, 1)),
                               (k == lefts - 1) || ($urandom_range(0, 9) == 0));
            end
            stage_no++;
        end

        steady = 1'b0;
        drain();
        if (mismatches == 0 && outstanding == 0)
            $display("sparse_coo_kronecker_product_unit_test passed");
        else
            $display("sparse_coo_kronecker_product_unit_test failed");
        $finish;
    end

    // run limit
    initial
    begin
        #(TIMEOUT_NS);
        $display("sparse_coo_kronecker_product_unit_test failed");
        $finish;
    end

endmodule
